// ===== src/decimal_text_to_scaled_integer_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for decimal_text_to_scaled_integer_core
// Clock and reset are the core's own clock and reset ports.
// ----------------------------------------------------------------------------
`ifndef DECIMAL_TEXT_TO_SCALED_INTEGER_CORE_MACROS_SVH
`define DECIMAL_TEXT_TO_SCALED_INTEGER_CORE_MACROS_SVH

// Condition holds in the same cycle as its cause.
`define DTSI_ASSERT_SAME(label, cause, effect) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
      else $error("dtsi assertion failed");

// Condition holds in the cycle after its cause.
`define DTSI_ASSERT_NEXT(label, cause, effect) \
   label: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
      else $error("dtsi assertion failed");

`endif

// ===== src/dtsi_pkg.sv =====
// ----------------------------------------------------------------------------
// dtsi_pkg
// Widths, character codes and parse state for the decimal text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsi_pkg;

   localparam int MAX_INT_DIGITS = 15;
   localparam int ACC_W          = 57;
   localparam int CNT_W          = $clog2(MAX_INT_DIGITS + 2);
   localparam int VALUE_W        = 50;

   localparam logic [7:0] CHAR_DOT  = 8'h2E;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   localparam logic [3:0] ROUND_DIGIT = 4'd5;

   localparam logic KIND_PRICE = 1'b0;
   localparam logic KIND_SIZE  = 1'b1;

   // fraction places still kept
   localparam logic [1:0] FRAC_KEEP_TWO  = 2'd2;
   localparam logic [1:0] FRAC_KEEP_ONE  = 2'd1;
   localparam logic [1:0] FRAC_KEEP_NONE = 2'd0;

   localparam logic [ACC_W-1:0] PRICE_MAX = ACC_W'(100);
   localparam logic [ACC_W-1:0] OUT_MAX   = ACC_W'(64'd1000000000000000);
   localparam logic [VALUE_W-1:0] PRICE_UNIT = VALUE_W'(100);

   typedef struct packed {
      logic [ACC_W-1:0] accumulator;
      logic [CNT_W-1:0] int_digit_count;
      logic [1:0]       frac_places_left;
      logic             dot_seen;
      logic             frac_digit_seen;
      logic             round_done;
      logic             nonzero_digit_seen;
      logic             malformed;
   } parse_state_type;

endpackage

`default_nettype wire

// ===== src/decimal_text_to_scaled_integer_core.sv =====
// ----------------------------------------------------------------------------
// decimal_text_to_scaled_integer_core
// Parses a decimal field one character word at a time into a scaled integer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | char_byte, char_present, field_kind, last_char
//  rsp     | out       | rsp_valid / rsp_ready | scaled_value, value_ok
//
//  One character word per cycle unless a stalled result holds the parser; a word
//  is captured by the input register and parsed from it by the parse state update.
//  A result word is offered from the output register once its last character is parsed.
//  Reset clears the parse state and both valid flags.
//  A stalled result holds the parser only when the next word ends a field.
// ----------------------------------------------------------------------------
`default_nettype none
`include "decimal_text_to_scaled_integer_core_macros.svh"

module decimal_text_to_scaled_integer_core (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [7:0]                       req_char_byte,
   input  wire logic                             req_char_present,
   input  wire logic                             req_field_kind,
   input  wire logic                             req_last_char,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [dtsi_pkg::VALUE_W-1:0]          rsp_scaled_value,
   output logic                                  rsp_value_ok
);

   logic                           in_vld_ff, in_vld_in;
   logic [7:0]                     in_char_ff;
   logic                           in_present_ff;
   logic                           in_kind_ff;
   logic                           in_last_ff;
   logic                           fire;

   dtsi_pkg::parse_state_type      parse_state_ff, parse_state_in, step_state;

   logic [dtsi_pkg::VALUE_W-1:0]   fin_value;
   logic                           fin_ok;
   logic                           out_vld_ff, out_vld_in;
   logic [dtsi_pkg::VALUE_W-1:0]   out_value_ff;
   logic                           out_ok_ff;

   // advance the held word unless it ends a field and the result slot is full
   assign fire      = in_vld_ff && (!in_last_ff || !out_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || fire;

   dtsi_char_step u_step (
      .cur_state    (parse_state_ff),
      .char_byte    (in_char_ff),
      .char_present (in_present_ff),
      .field_kind   (in_kind_ff),
      .next_state   (step_state)
   );

   dtsi_finish u_finish (
      .state        (step_state),
      .field_kind   (in_kind_ff),
      .scaled_value (fin_value),
      .value_ok     (fin_ok)
   );

   always_comb begin
      in_vld_in = in_vld_ff;
      if (req_valid && req_ready) begin
         in_vld_in = 1'b1;
      end else if (fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_comb begin
      parse_state_in = parse_state_ff;
      if (fire) begin
         parse_state_in = in_last_ff ? '0 : step_state;
      end
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (fire && in_last_ff) begin
         out_vld_in = 1'b1;
      end else if (rsp_ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         out_vld_ff     <= 1'b0;
         parse_state_ff <= '0;
      end else begin
         in_vld_ff      <= in_vld_in;
         out_vld_ff     <= out_vld_in;
         parse_state_ff <= parse_state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_char_ff    <= req_char_byte;
         in_present_ff <= req_char_present;
         in_kind_ff    <= req_field_kind;
         in_last_ff    <= req_last_char;
      end
      if (fire && in_last_ff) begin
         out_value_ff <= fin_value;
         out_ok_ff    <= fin_ok;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_scaled_value = out_value_ff;
   assign rsp_value_ok     = out_ok_ff;

   `DTSI_ASSERT_SAME(a_reject_zero, rsp_valid && !rsp_value_ok, rsp_scaled_value == '0)
   `DTSI_ASSERT_NEXT(a_last_gives_result, fire && in_last_ff, rsp_valid)
   `DTSI_ASSERT_SAME(a_too_many_digits,
      parse_state_ff.int_digit_count > dtsi_pkg::CNT_W'(dtsi_pkg::MAX_INT_DIGITS),
      parse_state_ff.malformed)
   `DTSI_ASSERT_SAME(a_places_need_dot,
      parse_state_ff.frac_places_left != dtsi_pkg::FRAC_KEEP_NONE, parse_state_ff.dot_seen)
   `DTSI_ASSERT_SAME(a_round_after_places, parse_state_ff.round_done,
      parse_state_ff.frac_places_left == dtsi_pkg::FRAC_KEEP_NONE)

endmodule

`default_nettype wire

// ===== src/dtsi_char_step.sv =====
// ----------------------------------------------------------------------------
// dtsi_char_step
// Next parse state for one character: digit accumulate, dot scaling,
// kept fraction places, half-up rounding and malformed detection.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsi_char_step (
   input  var dtsi_pkg::parse_state_type cur_state,
   input  wire logic [7:0]               char_byte,
   input  wire logic                     char_present,
   input  wire logic                     field_kind,
   output dtsi_pkg::parse_state_type     next_state
);

   logic [3:0]                   digit;
   logic                         is_digit;
   logic [dtsi_pkg::ACC_W-1:0]   acc;
   logic [dtsi_pkg::ACC_W-1:0]   acc_x10;
   logic [dtsi_pkg::ACC_W-1:0]   acc_x100;
   logic [dtsi_pkg::ACC_W-1:0]   digit_ext;
   logic [dtsi_pkg::ACC_W-1:0]   digit_x10;
   logic [dtsi_pkg::CNT_W-1:0]   cnt_inc;

   assign acc       = cur_state.accumulator;
   assign digit     = char_byte[3:0];
   assign is_digit  = (char_byte >= dtsi_pkg::CHAR_ZERO) && (char_byte <= dtsi_pkg::CHAR_NINE);
   assign acc_x10   = (acc << 3) + (acc << 1);
   assign acc_x100  = (acc << 6) + (acc << 5) + (acc << 2);
   assign digit_ext = dtsi_pkg::ACC_W'(digit);
   assign digit_x10 = (digit_ext << 3) + (digit_ext << 1);
   assign cnt_inc   = cur_state.int_digit_count + 1'b1;

   always_comb begin
      next_state = cur_state;
      if (char_present && !cur_state.malformed) begin
         priority if (char_byte == dtsi_pkg::CHAR_DOT) begin
            if (cur_state.dot_seen) begin
               next_state.malformed = 1'b1;
            end else begin
               next_state.dot_seen = 1'b1;
               if (field_kind == dtsi_pkg::KIND_PRICE) begin
                  next_state.accumulator      = acc_x100;
                  next_state.frac_places_left = dtsi_pkg::FRAC_KEEP_TWO;
               end else begin
                  next_state.frac_places_left = dtsi_pkg::FRAC_KEEP_NONE;
               end
            end
         end else if (!is_digit) begin
            next_state.malformed = 1'b1;
         end else begin
            if (digit != 4'd0) begin
               next_state.nonzero_digit_seen = 1'b1;
            end
            if (!cur_state.dot_seen) begin
               next_state.int_digit_count = cnt_inc;
               if (cnt_inc > dtsi_pkg::CNT_W'(dtsi_pkg::MAX_INT_DIGITS)) begin
                  next_state.malformed = 1'b1;
               end else begin
                  next_state.accumulator = acc_x10 + digit_ext;
               end
            end else begin
               next_state.frac_digit_seen = 1'b1;
               unique case (cur_state.frac_places_left)
                  dtsi_pkg::FRAC_KEEP_TWO: begin
                     next_state.accumulator      = acc + digit_x10;
                     next_state.frac_places_left = dtsi_pkg::FRAC_KEEP_ONE;
                  end
                  dtsi_pkg::FRAC_KEEP_ONE: begin
                     next_state.accumulator      = acc + digit_ext;
                     next_state.frac_places_left = dtsi_pkg::FRAC_KEEP_NONE;
                  end
                  default: begin
                     // first digit past the kept places rounds, later ones are only checked
                     if (!cur_state.round_done) begin
                        if (digit >= dtsi_pkg::ROUND_DIGIT) begin
                           next_state.accumulator = acc + 1'b1;
                        end
                        next_state.round_done = 1'b1;
                     end
                  end
               endcase
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== src/dtsi_finish.sv =====
// ----------------------------------------------------------------------------
// dtsi_finish
// Final checks on a completed field: digit presence, price range, tiny
// size bump to one, output range, and zeroing of rejected values.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsi_finish (
   input  var dtsi_pkg::parse_state_type     state,
   input  wire logic                         field_kind,
   output logic [dtsi_pkg::VALUE_W-1:0]      scaled_value,
   output logic                              value_ok
);

   logic                           form_ok;
   logic                           range_ok;
   logic [dtsi_pkg::VALUE_W-1:0]   value;
   logic                           acc_zero;

   assign acc_zero = (state.accumulator == '0);
   assign form_ok  = !state.malformed &&
                     ((state.int_digit_count != '0) || state.frac_digit_seen);

   always_comb begin
      if (field_kind == dtsi_pkg::KIND_PRICE) begin
         if (state.dot_seen) begin
            range_ok = (state.accumulator <= dtsi_pkg::PRICE_MAX);
            value    = state.accumulator[dtsi_pkg::VALUE_W-1:0];
         end else begin
            // integer price still needs its scale: only 0 or 1 stays in range
            range_ok = (state.accumulator <= dtsi_pkg::ACC_W'(1));
            value    = state.accumulator[0] ? dtsi_pkg::PRICE_UNIT : '0;
         end
      end else begin
         range_ok = (state.accumulator <= dtsi_pkg::OUT_MAX);
         if (acc_zero && state.nonzero_digit_seen) begin
            value = dtsi_pkg::VALUE_W'(1);
         end else begin
            value = state.accumulator[dtsi_pkg::VALUE_W-1:0];
         end
      end
   end

   assign value_ok     = form_ok && range_ok;
   assign scaled_value = value_ok ? value : '0;

endmodule

`default_nettype wire

// ===== test/tb_decimal_text_to_scaled_integer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_text_to_scaled_integer_core
// Feeds decimal fields one character word at a time, mixing short directed
// fields with random well-formed, broken and noise fields. A local parser
// computes each field's scaled value and valid flag, and every result word
// is compared against it in order. Both channels idle at random, and the
// result side holds off once for a long stretch.
// ----------------------------------------------------------------------------

module tb_decimal_text_to_scaled_integer_core;

   localparam int HALF_PERIOD  = 6;
   localparam int RESET_CYCLES = 9;
   localparam int WORD_TARGET  = 1450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 300;
   localparam int PRICE_SCALE  = 100;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       present;
      logic       kind;
      logic       last;
   } char_word_type;

   typedef struct packed {
      logic [dtsi_pkg::VALUE_W-1:0] value;
      logic                         ok;
   } parsed_value_type;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_char_byte = 8'h00;
   logic                           req_char_present = 1'b0;
   logic                           req_field_kind = dtsi_pkg::KIND_PRICE;
   logic                           req_last_char = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic [dtsi_pkg::VALUE_W-1:0]   rsp_scaled_value;
   logic                           rsp_value_ok;

   char_word_type    char_queue[$];
   parsed_value_type value_queue[$];

   // local copy of the parse state
   logic [dtsi_pkg::ACC_W-1:0] fld_acc;
   int                         fld_int_digits;
   logic [1:0]                 fld_places;
   logic                       fld_dot;
   logic                       fld_frac_digit;
   logic                       fld_round_done;
   logic                       fld_nonzero;
   logic                       fld_malformed;

   int  cycle_count = 0;
   int  error_count = 0;
   int  total_words = 1;
   int  words_offered = 0;
   int  field_count = 0;
   int  results_checked = 0;
   int  ok_results = 0;
   int  phase = 0;
   int  hold_left = 0;
   bit  hold_done = 0;
   logic req_taken = 1'b0;

   decimal_text_to_scaled_integer_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_byte    (req_char_byte),
      .req_char_present (req_char_present),
      .req_field_kind   (req_field_kind),
      .req_last_char    (req_last_char),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_scaled_value (rsp_scaled_value),
      .rsp_value_ok     (rsp_value_ok)
   );

   always begin
      clock = 1'b0;
      #HALF_PERIOD;
      clock = 1'b1;
      #HALF_PERIOD;
   end

   function automatic void clear_field();
      fld_acc        = '0;
      fld_int_digits = 0;
      fld_places     = dtsi_pkg::FRAC_KEEP_NONE;
      fld_dot        = 1'b0;
      fld_frac_digit = 1'b0;
      fld_round_done = 1'b0;
      fld_nonzero    = 1'b0;
      fld_malformed  = 1'b0;
   endfunction

   function automatic void absorb_char(input logic [7:0] c, input logic is_price);
      logic [3:0] d;
      if (fld_malformed) return;
      if (c == dtsi_pkg::CHAR_DOT) begin
         if (fld_dot) begin
            fld_malformed = 1'b1;
            return;
         end
         fld_dot = 1'b1;
         if (is_price) begin
            fld_acc    = fld_acc * PRICE_SCALE;
            fld_places = dtsi_pkg::FRAC_KEEP_TWO;
         end else begin
            fld_places = dtsi_pkg::FRAC_KEEP_NONE;
         end
         return;
      end
      if (c < dtsi_pkg::CHAR_ZERO || c > dtsi_pkg::CHAR_NINE) begin
         fld_malformed = 1'b1;
         return;
      end
      d = 4'(c - dtsi_pkg::CHAR_ZERO);
      if (d != 4'd0) fld_nonzero = 1'b1;
      if (!fld_dot) begin
         fld_int_digits++;
         if (fld_int_digits > dtsi_pkg::MAX_INT_DIGITS) begin
            fld_malformed = 1'b1;
            return;
         end
         fld_acc = fld_acc * 10 + d;
         return;
      end
      fld_frac_digit = 1'b1;
      if (fld_places == dtsi_pkg::FRAC_KEEP_TWO) begin
         fld_acc    = fld_acc + d * 10;
         fld_places = dtsi_pkg::FRAC_KEEP_ONE;
      end else if (fld_places == dtsi_pkg::FRAC_KEEP_ONE) begin
         fld_acc    = fld_acc + d;
         fld_places = dtsi_pkg::FRAC_KEEP_NONE;
      end else if (!fld_round_done) begin
         // first digit past the kept places rounds half up
         if (d >= dtsi_pkg::ROUND_DIGIT) fld_acc = fld_acc + 1;
         fld_round_done = 1'b1;
      end
   endfunction

   // Advance the parse state by one word; returns 1 when the word ends a field.
   function automatic bit parse_word(input char_word_type w, output parsed_value_type r);
      logic [dtsi_pkg::ACC_W-1:0] v;
      logic                       ok;
      logic                       is_price;
      r = '0;
      is_price = (w.kind == dtsi_pkg::KIND_PRICE);
      if (w.present) absorb_char(w.char_byte, is_price);
      if (!w.last) return 1'b0;
      ok = !fld_malformed;
      v  = fld_acc;
      if (ok && fld_int_digits == 0 && !fld_frac_digit) ok = 1'b0;
      if (ok && !fld_dot && is_price) v = v * PRICE_SCALE;
      if (ok) begin
         if (is_price) begin
            if (v > dtsi_pkg::PRICE_MAX) ok = 1'b0;
         end else if (v == 0 && fld_nonzero) begin
            v = 1;
         end
      end
      if (ok && v > dtsi_pkg::OUT_MAX) ok = 1'b0;
      r.value = ok ? v[dtsi_pkg::VALUE_W-1:0] : '0;
      r.ok    = ok;
      clear_field();
      return 1'b1;
   endfunction

   task automatic push_word(input logic [7:0] b, input logic present, input logic kind,
                            input logic last);
      char_word_type w;
      w.char_byte = b;
      w.present   = present;
      w.kind      = kind;
      w.last      = last;
      char_queue = {char_queue, w};
      if (last) field_count++;
   endtask

   task automatic push_text(input string s, input logic kind);
      for (int i = 0; i < s.len(); i++)
         push_word(s[i], 1'b1, kind, i == s.len() - 1);
   endtask

   // Build one random field; returns the number of words it queued.
   task automatic add_random_field(output int counted);
      logic [7:0] text[$];
      logic       kind;
      logic       with_dot;
      bit         zero_heavy;
      int         shape, pick, n_int, n_frac, idx;
      counted  = 0;
      kind     = 1'($urandom_range(0, 1));
      shape    = $urandom_range(0, 99);
      if (shape < 8) begin
         repeat ($urandom_range(1, 6)) text = {text, 8'($urandom_range(0, 255))};
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 6)       n_int = dtsi_pkg::MAX_INT_DIGITS;
         else if (pick < 10) n_int = dtsi_pkg::MAX_INT_DIGITS + 1;
         else if (pick < 20) n_int = $urandom_range(4, dtsi_pkg::MAX_INT_DIGITS - 1);
         else                n_int = $urandom_range(0, 3);
         with_dot   = ($urandom_range(0, 3) != 0);
         n_frac     = with_dot ? $urandom_range(0, 5) : 0;
         zero_heavy = ($urandom_range(0, 2) == 0);
         for (int i = 0; i < n_int + n_frac; i++) begin
            if (with_dot && i == n_int) text = {text, dtsi_pkg::CHAR_DOT};
            if (zero_heavy && $urandom_range(0, 3) != 0)
               text = {text, dtsi_pkg::CHAR_ZERO};
            else
               text = {text, 8'(dtsi_pkg::CHAR_ZERO + $urandom_range(0, 9))};
         end
         if (with_dot && n_frac == 0) text = {text, dtsi_pkg::CHAR_DOT};
         if (shape < 20) begin
            // break a well-formed field
            if (text.size() == 0) begin
               text = {text, 8'($urandom_range(0, 255))};
            end else begin
               idx = $urandom_range(0, text.size() - 1);
               if ($urandom_range(0, 1) == 0) text[idx] = 8'($urandom_range(0, 255));
               else text.insert(idx, dtsi_pkg::CHAR_DOT);
            end
         end
      end
      if (text.size() == 0) begin
         push_word(8'($urandom_range(0, 255)), 1'b0, kind, 1'b1);
         counted = 1;
         return;
      end
      foreach (text[i]) begin
         if ($urandom_range(0, 11) == 0) begin
            push_word(8'($urandom_range(0, 255)), 1'b0, kind, 1'b0);
            counted++;
         end
         push_word(text[i], 1'b1, kind ^ ($urandom_range(0, 19) == 0),
                   i == text.size() - 1 && $urandom_range(0, 9) != 0);
         counted++;
      end
      // close with an empty word when the last character did not
      if (!char_queue[$].last) begin
         push_word(8'($urandom_range(0, 255)), 1'b0, kind, 1'b1);
         counted++;
      end
   endtask

   // drive request words at the falling edge
   always @(negedge clock) begin : feed
      char_word_type w;
      int            idle_pct;
      idle_pct = (phase == 0) ? 23 : (phase == 1) ? 70 : 0;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (char_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            w = char_queue.pop_front();
            req_valid        <= 1'b1;
            req_char_byte    <= w.char_byte;
            req_char_present <= w.present;
            req_field_kind   <= w.kind;
            req_last_char    <= w.last;
            words_offered++;
            phase <= (words_offered * 3) / total_words;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result side: random stalls plus one long hold-off in the last phase
   always @(negedge clock) begin : drain
      int idle_pct;
      idle_pct = (phase == 0) ? 70 : (phase == 1) ? 23 : 0;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && phase >= 2) begin
         rsp_ready <= 1'b0;
         hold_left <= LONG_HOLD;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= idle_pct);
      end
   end

   always @(posedge clock) begin : watch
      char_word_type    w;
      parsed_value_type want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("decimal_text_to_scaled_integer_core: mismatch");
         $finish;
      end else begin
         req_taken <= !reset && req_valid && req_ready;
         if (!reset && rsp_valid && rsp_ready) begin
            if (value_queue.size() == 0) begin
               error_count++;
               $display("%0t: unexpected result word value=%0d ok=%0b", $time,
                        rsp_scaled_value, rsp_value_ok);
            end else begin
               want = value_queue.pop_front();
               results_checked++;
               if (want.ok) ok_results++;
               if (rsp_scaled_value !== want.value) begin
                  error_count++;
                  $display("%0t: scaled_value expected %0d got %0d", $time, want.value,
                           rsp_scaled_value);
               end
               if (rsp_value_ok !== want.ok) begin
                  error_count++;
                  $display("%0t: value_ok expected %0b got %0b", $time, want.ok,
                           rsp_value_ok);
               end
            end
         end
         if (!reset && req_valid && req_ready) begin
            w.char_byte = req_char_byte;
            w.present   = req_char_present;
            w.kind      = req_field_kind;
            w.last      = req_last_char;
            if (parse_word(w, want)) value_queue = {value_queue, want};
         end
      end
   end

   initial begin : stimulus
      int counted, n;
      clear_field();
      // directed fields
      push_word(8'h00, 1'b0, dtsi_pkg::KIND_SIZE, 1'b1);   // empty field
      push_word(8'hFF, 1'b1, dtsi_pkg::KIND_PRICE, 1'b1);  // bad byte, all ones
      push_word(8'h00, 1'b1, dtsi_pkg::KIND_SIZE, 1'b1);   // bad byte, all zeros
      push_text(".", dtsi_pkg::KIND_PRICE);                // dot with no digit
      push_text("5.", dtsi_pkg::KIND_SIZE);                // trailing dot is fine
      push_text("0.995", dtsi_pkg::KIND_PRICE);            // rounds up to the top of range
      push_text("1.005", dtsi_pkg::KIND_PRICE);            // rounds past the top of range
      push_text("0.4", dtsi_pkg::KIND_SIZE);               // tiny size becomes one
      push_text("1..", dtsi_pkg::KIND_SIZE);               // second dot
      push_text("100", dtsi_pkg::KIND_PRICE);              // price above range
      // random fields
      n = char_queue.size();
      while (n < WORD_TARGET) begin
         add_random_field(counted);
         n += counted;
      end
      total_words = char_queue.size();

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_valid) @(posedge clock);
      while (value_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d fields in %0d character words over %0d cycles", field_count,
               total_words, cycle_count);
      $display("Checked %0d result words: %0d valid, %0d flagged", results_checked,
               ok_results, results_checked - ok_results);
      if (error_count == 0)
         $display("decimal_text_to_scaled_integer_core: match");
      else
         $display("decimal_text_to_scaled_integer_core: mismatch");
      $finish;
   end

endmodule
